// ===== hdl/compression_magic_scanner_macros.svh =====
// assertion macros shared by the scanner rtl
// clocked on clk; CMS_ASSERT is disabled while rst_n is low; empty when SYNTH is defined
`ifndef COMPRESSION_MAGIC_SCANNER_MACROS_SVH
`define COMPRESSION_MAGIC_SCANNER_MACROS_SVH
`ifndef SYNTH
// property checked only outside reset
`define CMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked on every edge, reset included
`define CMS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CMS_ASSERT(lbl, prop, msg)
`define CMS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/cms_pkg.sv =====
// types and constants of the compression magic scanner
// no dependencies; imported by every scanner module
package cms_pkg;

    localparam int CMS_OFFSET_BITS = 32;
    localparam int OUT_OFFSET_W    = 32;
    localparam int WIN_LEN         = 13;
    localparam int FILL_W          = $clog2(WIN_LEN + 1);

    // result queue between scanner and consumer
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [2:0] KIND_GZIP  = 3'd0;
    localparam logic [2:0] KIND_BZIP2 = 3'd1;
    localparam logic [2:0] KIND_XZ    = 3'd2;
    localparam logic [2:0] KIND_ZSTD  = 3'd3;
    localparam logic [2:0] KIND_LZMA  = 3'd4;

    localparam logic [23:0] GZIP_HDR  = 24'h1F8B08;
    localparam logic [23:0] BZIP2_HDR = 24'h425A68;
    localparam logic [47:0] XZ_HDR    = 48'hFD377A585A00;
    localparam logic [31:0] ZSTD_HDR  = 32'h28B52FFD;

    localparam logic [7:0] LZMA_PROPS     = 8'h5D;
    localparam logic [7:0] LZMA_DICT_LIM  = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic                    found;
        logic [2:0]              kind;
        logic [OUT_OFFSET_W-1:0] start_offset;
    } out_item_t;

endpackage

// ===== hdl/compression_magic_scanner.sv =====
// top level of the compression magic scanner
// depends on cms_pkg, cms_front and cms_queue
//
//  channel   request      handshake      accepted when
//  input     item         push / full    push && !full
//  result    result       pop / empty    pop && !empty
//
// one byte is taken per cycle while full is low; window shift, magic
// compares and offset subtract all settle in the cycle the byte is taken
// a result enters the four-entry result queue in that same cycle and can be
// popped on the next edge
// full rises only when four results wait unpopped; input then stalls
// reset clears window, counters and queue; no clearing pass is needed
module compression_magic_scanner
    import cms_pkg::*;
#(
    parameter int OFFSET_BITS = CMS_OFFSET_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic      take;
    logic      res_valid;
    out_item_t res;

    assign take = push && !full;

    cms_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    cms_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_valid),
        .wdata (res),
        .full  (full),
        .empty (empty),
        .pop   (pop),
        .rdata (result)
    );

endmodule

// ===== hdl/cms_front.sv =====
// front end: byte window, offset counter, magic and lzma classification
// depends on cms_pkg and the scanner assertion macros
`include "compression_magic_scanner_macros.svh"

module cms_front
    import cms_pkg::*;
#(
    parameter int OFFSET_BITS = CMS_OFFSET_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  in_item_t  item,
    output logic      res_valid,
    output out_item_t res
);

    logic [7:0]              window_reg [WIN_LEN];
    logic [FILL_W-1:0]       filled_reg;
    logic [OFFSET_BITS-1:0]  pos_reg;
    logic                    lzma_seen_reg;
    logic [OUT_OFFSET_W-1:0] lzma_pos_reg;
    logic                    reported_reg;

    logic [7:0]              win_new [WIN_LEN];
    logic [FILL_W-1:0]       filled_next;
    logic [OFFSET_BITS-1:0]  pos_next;
    logic                    pos_at_max;
    logic                    m_gzip, m_bzip2, m_xz, m_zstd, hit;
    logic [2:0]              fix_kind;
    logic [3:0]              fix_back;
    logic [OFFSET_BITS-1:0]  fix_back_w, lz_back_w;
    logic [OFFSET_BITS-1:0]  fix_start, lz_start;
    logic [OFFSET_BITS+31:0] fix_ext, lz_ext;
    logic [OUT_OFFSET_W-1:0] fix_out, lz_out;
    logic                    lz_zeros, lz_ones, lz_rule, lz_now, lz_any;

    // shifted window with the new byte at the newest end
    always_comb
    begin
        for (int i = 0; i < WIN_LEN - 1; i++)
        begin
            win_new[i] = window_reg[i+1];
        end
        win_new[WIN_LEN-1] = item.data_byte;
    end

    assign filled_next = (filled_reg == FILL_W'(WIN_LEN)) ? filled_reg
                                                           : filled_reg + FILL_W'(1);
    assign pos_at_max  = (pos_reg == '1);
    assign pos_next    = pos_at_max ? pos_reg : pos_reg + OFFSET_BITS'(1);

    assign m_gzip  = (filled_next >= FILL_W'(3)) &&
                     ({win_new[10], win_new[11], win_new[12]} == GZIP_HDR);
    assign m_bzip2 = (filled_next >= FILL_W'(3)) &&
                     ({win_new[10], win_new[11], win_new[12]} == BZIP2_HDR);
    assign m_xz    = (filled_next >= FILL_W'(6)) &&
                     ({win_new[7], win_new[8], win_new[9], win_new[10], win_new[11],
                       win_new[12]} == XZ_HDR);
    assign m_zstd  = (filled_next >= FILL_W'(4)) &&
                     ({win_new[9], win_new[10], win_new[11], win_new[12]} == ZSTD_HDR);
    assign hit     = m_gzip || m_bzip2 || m_xz || m_zstd;

    always_comb
    begin
        fix_kind = KIND_ZSTD;
        fix_back = 4'd3;
        if (m_gzip)
        begin
            fix_kind = KIND_GZIP;
            fix_back = 4'd2;
        end
        else if (m_bzip2)
        begin
            fix_kind = KIND_BZIP2;
            fix_back = 4'd2;
        end
        else if (m_xz)
        begin
            fix_kind = KIND_XZ;
            fix_back = 4'd5;
        end
    end

    // offset of the first byte of the match, pinned at the counter maximum
    assign fix_back_w = OFFSET_BITS'(fix_back);
    assign lz_back_w  = OFFSET_BITS'(WIN_LEN - 1);
    assign fix_start  = pos_at_max ? pos_reg :
                        (pos_reg >= fix_back_w) ? pos_reg - fix_back_w : '0;
    assign lz_start   = pos_at_max ? pos_reg :
                        (pos_reg >= lz_back_w) ? pos_reg - lz_back_w : '0;

    // clamp to the 32-bit result field
    assign fix_ext = {32'b0, fix_start};
    assign lz_ext  = {32'b0, lz_start};
    assign fix_out = (|fix_ext[OFFSET_BITS+31:32]) ? '1 : fix_ext[31:0];
    assign lz_out  = (|lz_ext[OFFSET_BITS+31:32]) ? '1 : lz_ext[31:0];

    always_comb
    begin
        lz_zeros = 1'b1;
        lz_ones  = 1'b1;
        for (int i = 10; i < WIN_LEN; i++)
        begin
            if (win_new[i] != 8'h00)
            begin
                lz_zeros = 1'b0;
            end
        end
        for (int i = 5; i < WIN_LEN; i++)
        begin
            if (win_new[i] != 8'hFF)
            begin
                lz_ones = 1'b0;
            end
        end
    end

    assign lz_rule = (filled_next == FILL_W'(WIN_LEN)) && (win_new[0] == LZMA_PROPS) &&
                     (win_new[4] < LZMA_DICT_LIM) && (lz_zeros || lz_ones);
    assign lz_now  = !lzma_seen_reg && !hit && lz_rule;
    assign lz_any  = lzma_seen_reg || lz_now;

    assign res_valid = take && !reported_reg && (hit || item.last);

    always_comb
    begin
        res.found        = hit || lz_any;
        res.kind         = KIND_GZIP;
        res.start_offset = '0;
        if (hit)
        begin
            res.kind         = fix_kind;
            res.start_offset = fix_out;
        end
        else if (lzma_seen_reg)
        begin
            res.kind         = KIND_LZMA;
            res.start_offset = lzma_pos_reg;
        end
        else if (lz_now)
        begin
            res.kind         = KIND_LZMA;
            res.start_offset = lz_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                window_reg[i] <= '0;
            end
            filled_reg    <= '0;
            pos_reg       <= '0;
            lzma_seen_reg <= 1'b0;
            lzma_pos_reg  <= '0;
            reported_reg  <= 1'b0;
        end
        else if (take)
        begin
            if (item.last)
            begin
                // end of stream: next byte starts a new one
                for (int i = 0; i < WIN_LEN; i++)
                begin
                    window_reg[i] <= '0;
                end
                filled_reg    <= '0;
                pos_reg       <= '0;
                lzma_seen_reg <= 1'b0;
                lzma_pos_reg  <= '0;
                reported_reg  <= 1'b0;
            end
            else if (!reported_reg)
            begin
                for (int i = 0; i < WIN_LEN; i++)
                begin
                    window_reg[i] <= win_new[i];
                end
                filled_reg   <= filled_next;
                pos_reg      <= pos_next;
                reported_reg <= hit;
                if (lz_now)
                begin
                    lzma_seen_reg <= 1'b1;
                    lzma_pos_reg  <= lz_out;
                end
            end
        end
    end

    `CMS_ASSERT(a_last_clears, (take && item.last) |=> (pos_reg == '0 && filled_reg == '0 && !reported_reg && !lzma_seen_reg), "stream state not cleared after last byte")
    `CMS_ASSERT(a_silent_after_report, (take && reported_reg) |-> !res_valid, "result after a report in the same stream")
    `CMS_ASSERT(a_lzma_full_window, lzma_seen_reg |-> (filled_reg == FILL_W'(WIN_LEN)), "lzma recorded before the window filled")
    `CMS_ASSERT(a_hit_reports, (take && !reported_reg && hit && !item.last) |=> reported_reg, "magic hit not marked as reported")

endmodule

// ===== hdl/cms_queue.sv =====
// result queue between the scanner front end and the consumer
// depends on cms_pkg and the scanner assertion macros
`include "compression_magic_scanner_macros.svh"

module cms_queue
    import cms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  out_item_t wdata,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output out_item_t rdata
);

    out_item_t         mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              rd, wr_ok;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign rd    = pop && !empty;
    assign wr_ok = wr && !full;
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_ok)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
            end
            if (rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
            end
            if (wr_ok && !rd)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (rd && !wr_ok)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    `CMS_ASSERT(a_no_overflow, wr |-> !full, "result request dropped on a full queue")
    `CMS_ASSERT(a_write_shows, (wr_ok && !rd) |=> !empty, "written result not visible")
    `CMS_ASSERT(a_drain_empty, (rd && !wr_ok && count_reg == QCNT_W'(1)) |=> empty, "queue not empty after last pop")
    `CMS_ASSERT(a_count_bound, count_reg <= QCNT_W'(QDEPTH), "queue count beyond depth")

endmodule
